>>> rtl/core/kem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kem_pkg
// Shared types and constants for the key exact or substring match block.
// ----------------------------------------------------------------------------
package kem_pkg;

  localparam int KEY_MAX_DEF = 16;   // default window depth and key capacity
  localparam int KEY_BYTES   = 16;   // bytes held by the two key registers
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int KEY_IDX_W   = 4;    // index into the sixteen key bytes
  localparam int LEN_W       = 5;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CNT_W-1:0] CNT_SAT = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTAIN  = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] key_length;
    logic             contain_mode;
  } cfg_t;

endpackage

>>> rtl/core/kem_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kem_in_stage
// Input register: holds one text byte until the match core consumes it.
// ----------------------------------------------------------------------------
module kem_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kem_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output kem_pkg::item_t item
);
  import kem_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // The register can refill in the same cycle that its byte is consumed.
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/core/kem_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kem_core
// Window, count and flag update for one byte, with the result register.
// ----------------------------------------------------------------------------
module kem_core #(
  parameter int KEY_MAX = kem_pkg::KEY_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kem_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  kem_pkg::item_t item,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_matched
);
  import kem_pkg::*;

  logic [7:0]       win_r [KEY_MAX];
  logic [7:0]       win_new [KEY_MAX];
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] seen_nxt;
  logic             found_r;
  logic             found_nxt;
  logic             prefix_r;
  logic             prefix_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             matched_r;
  logic             matched_nxt;
  logic             usable;
  logic             miss;
  logic [CNT_W-1:0] len_ext;

  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                          input logic [KEY_IDX_W-1:0] idx);
    return key[8*idx +: 8];
  endfunction

  // A byte without the last mark never needs the result register.
  assign take = item_valid && (!item.last_byte || !out_valid_r || out_ready);

  assign usable  = (cfg.key_length != '0) && (cfg.key_length <= LEN_W'(KEY_MAX));
  assign len_ext = CNT_W'(cfg.key_length);

  always_comb begin
    win_new[0] = item.text_byte;
    for (int k = 1; k < KEY_MAX; k++) begin
      win_new[k] = win_r[k-1];
    end
  end

  assign seen_nxt = (seen_r == CNT_SAT) ? CNT_SAT : seen_r + 1'b1;

  // The key ends at this byte when window entry k holds key byte len-1-k.
  always_comb begin
    logic [LEN_W-1:0] kidx;
    miss = 1'b0;
    for (int k = 0; k < KEY_MAX; k++) begin
      kidx = cfg.key_length - 1'b1 - LEN_W'(k);
      if ((LEN_W'(k) < cfg.key_length) &&
          (win_new[k] != key_byte(cfg.key, kidx[KEY_IDX_W-1:0]))) begin
        miss = 1'b1;
      end
    end
  end

  always_comb begin
    prefix_nxt = prefix_r;
    if (usable && (seen_r < len_ext) &&
        (item.text_byte != key_byte(cfg.key, seen_r[KEY_IDX_W-1:0]))) begin
      prefix_nxt = 1'b0;
    end
    found_nxt = found_r || (usable && (seen_nxt >= len_ext) && !miss);
    if (!usable) begin
      matched_nxt = 1'b0;
    end else if (cfg.contain_mode) begin
      matched_nxt = found_nxt;
    end else begin
      matched_nxt = prefix_nxt && (seen_nxt == len_ext);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && item.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      found_r     <= 1'b0;
      prefix_r    <= 1'b1;
      for (int k = 0; k < KEY_MAX; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (item.last_byte) begin
          // End of text: the next byte starts a fresh search.
          seen_r   <= '0;
          found_r  <= 1'b0;
          prefix_r <= 1'b1;
          for (int k = 0; k < KEY_MAX; k++) begin
            win_r[k] <= '0;
          end
        end else begin
          seen_r   <= seen_nxt;
          found_r  <= found_nxt;
          prefix_r <= prefix_nxt;
          for (int k = 0; k < KEY_MAX; k++) begin
            win_r[k] <= win_new[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      matched_r <= matched_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = matched_r;

endmodule

>>> rtl/core/key_exact_or_substring_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_exact_or_substring_match
// Checks a streamed text against a configured key, exactly or as a substring.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle while the output side is not
// stalled. A byte sits in the input register, then a combinational compare of
// the KEY_MAX-byte window against the key updates the count and flags; that
// compare sets the rate of one byte per cycle. The result for a text appears on
// out_matched at the same edge that takes its last byte out of the input
// register. The user must write configuration only while no text is in flight;
// the block itself does not enforce it.
module key_exact_or_substring_match #(
  parameter int KEY_MAX = kem_pkg::KEY_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kem_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_matched
);
  import kem_pkg::*;

  logic [CFG_DATA_W-1:0] key_low_r;
  logic [CFG_DATA_W-1:0] key_high_r;
  logic [LEN_W-1:0]      key_len_r;
  logic                  contain_r;
  cfg_t                  cfg;
  item_t                 in_item;
  item_t                 item;
  logic                  item_valid;
  logic                  take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
      contain_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LEN:  key_len_r  <= cfg_data[LEN_W-1:0];
        CFG_CONTAIN:  contain_r  <= cfg_data[0];
      endcase
    end
  end

  assign cfg.key          = {key_high_r, key_low_r};
  assign cfg.key_length   = key_len_r;
  assign cfg.contain_mode = contain_r;

  assign in_item.text_byte = in_text_byte;
  assign in_item.last_byte = in_last_byte;

  kem_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  kem_core #(
    .KEY_MAX (KEY_MAX)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_matched (out_matched)
  );

endmodule

>>> rtl/core/kem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kem_checker
// Port-level checks for the key match block, bound to its top level.
// ----------------------------------------------------------------------------
module kem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // Input only stalls when a finished result is waiting on the output side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
      !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> $stable(out_matched))
    else $error("result changed while stalled");

endmodule

bind key_exact_or_substring_match kem_checker u_kem_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_matched (out_matched)
);

>>> test/key_exact_or_substring_match_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_exact_or_substring_match_tb
// Self-checking testbench for the key exact or substring match block.
// ----------------------------------------------------------------------------
// A table of directed texts covers reset values, the widest keys, register
// masking, bad key lengths and a count that saturates. Random texts follow
// under changing keys and modes, most of them built around the key. An
// in-bench tracker follows every accepted byte and queues the match flag
// that each text should give, and every result transfer is checked against
// the oldest queued flag. Both channels idle at random in several phases.
// One phase holds the output off for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module key_exact_or_substring_match_tb;
  import kem_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 12;
  localparam int PHASE_BYTES  = 90;

  typedef enum int {TXT_KEY, TXT_FILL, TXT_TAIL} text_kind_e;

  typedef struct {
    bit          wr;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_d;
    logic [63:0] cont_d;
    text_kind_e  kind;
    int          n;
    logic [7:0]  fill;
    int          want;
  } dir_row_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_text_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  out_matched;

  // Key registers as the block should hold them.
  logic [63:0]      key_lo   = '0;
  logic [63:0]      key_hi   = '0;
  logic [LEN_W-1:0] key_len  = '0;
  logic             contain  = 1'b0;

  // Running state of the text in progress.
  logic [7:0]       window [KEY_MAX_DEF];
  logic [CNT_W-1:0] seen_cnt;
  logic             found;
  logic             prefix_ok;

  logic       match_q [$];
  logic [7:0] text_buf [$];
  int         pinned_want  = -1;
  int         texts_sent   = 0;
  int         results_seen = 0;
  int         errors       = 0;
  int         prints       = 0;
  int         cycles       = 0;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         hold_left    = 0;
  int         phase_bytes  = 0;

  key_exact_or_substring_match u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_matched  (out_matched)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] key_byte(input int pos);
    if (pos < 8) begin
      return key_lo[8*pos +: 8];
    end
    return key_hi[8*(pos-8) +: 8];
  endfunction

  function automatic void clear_text();
    foreach (window[k]) window[k] = '0;
    seen_cnt  = '0;
    found     = 1'b0;
    prefix_ok = 1'b1;
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(1)) begin
      return key_byte($urandom_range(KEY_MAX_DEF - 1));
    end
    return 8'($urandom);
  endfunction

  initial clear_text();

  task automatic report(input string what, input logic got, input logic want);
    errors++;
    if (prints < MAX_PRINTS) begin
      prints++;
      $display("ERROR at %0t ns: %s (got %b, wanted %b)", $time, what, got, want);
    end
  endtask

  // Follows one accepted byte; queues the match flag when the text ends.
  task automatic track_text_byte(input logic [7:0] b, input logic last);
    int len;
    bit usable;
    bit hit;
    bit ok;
    len    = int'(key_len);
    usable = (len >= 1) && (len <= KEY_MAX_DEF);
    if (usable && int'(seen_cnt) < len && b != key_byte(int'(seen_cnt))) prefix_ok = 1'b0;
    for (int k = KEY_MAX_DEF - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (seen_cnt != CNT_SAT) seen_cnt++;
    if (usable && int'(seen_cnt) >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (window[k] != key_byte(len - 1 - k)) hit = 1'b0;
      end
      if (hit) found = 1'b1;
    end
    if (last) begin
      ok = usable && (contain ? found : (prefix_ok && int'(seen_cnt) == len));
      match_q.push_back(pinned_want >= 0 ? pinned_want[0] : ok);
      clear_text();
    end
  endtask

  // Check results before taking in new bytes, so a fresh flag is never
  // compared in the same edge that queues it.
  always @(posedge clk) begin : score
    logic want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (match_q.size() == 0) begin
          report("result transfer with no text pending", out_matched, 1'bx);
        end else begin
          want = match_q.pop_front();
          if (out_matched !== want) report("matched differs", out_matched, want);
        end
      end
      if (in_valid && in_ready) track_text_byte(in_text_byte, in_last_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
    phase_bytes += text_buf.size();
  endtask

  // Wait until every text has produced its result and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen != texts_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_key(input logic [63:0] lo, hi, len_d, cont_d);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [63:0]          vals [4];
    regs = '{CFG_KEY_LOW, CFG_KEY_HIGH, CFG_KEY_LEN, CFG_CONTAIN};
    vals = '{lo, hi, len_d, cont_d};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      case (regs[i])
        CFG_KEY_LOW:  key_lo  = vals[i];
        CFG_KEY_HIGH: key_hi  = vals[i];
        CFG_KEY_LEN:  key_len = vals[i][LEN_W-1:0];
        default:      contain = vals[i][0];
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic program_random();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_d;
    logic [63:0] cont_d;
    int          len;
    int          r;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    // A two-letter key gives overlapping partial matches.
    if ($urandom_range(1)) begin
      for (int b = 0; b < 8; b++) begin
        lo[8*b +: 8] = 8'h41 + 8'($urandom_range(1));
        hi[8*b +: 8] = 8'h41 + 8'($urandom_range(1));
      end
    end
    r = $urandom_range(99);
    if (r < 6) begin
      len = 0;
    end else if (r < 12) begin
      len = $urandom_range(31, KEY_MAX_DEF + 1);
    end else if (r < 24) begin
      len = KEY_MAX_DEF;
    end else if (r < 60) begin
      len = $urandom_range(4, 1);
    end else begin
      len = $urandom_range(KEY_MAX_DEF - 1, 5);
    end
    len_d  = {$urandom, $urandom};
    len_d[LEN_W-1:0] = len[LEN_W-1:0];
    cont_d = {$urandom, $urandom};
    cont_d[0] = 1'($urandom_range(1));
    program_key(lo, hi, len_d, cont_d);
  endtask

  function automatic void build_text(input text_kind_e kind, input int n,
                                     input logic [7:0] fill);
    int eff;
    eff = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
    text_buf.delete();
    for (int p = 0; p < n; p++) begin
      case (kind)
        TXT_KEY:  text_buf.push_back(key_byte(p % KEY_MAX_DEF));
        TXT_FILL: text_buf.push_back(fill);
        default:  text_buf.push_back(p < n - eff ? fill : key_byte(p - (n - eff)));
      endcase
    end
  endfunction

  task automatic random_text();
    int eff;
    int n;
    int r;
    int pos;
    eff = (key_len >= 1 && key_len <= KEY_MAX_DEF) ? int'(key_len) : $urandom_range(4, 1);
    text_buf.delete();
    r = $urandom_range(99);
    if ($urandom_range(79) == 0) begin
      // Long text: the byte count can saturate before the end.
      n = $urandom_range(270, 250);
      repeat (n - eff) text_buf.push_back(noise_byte());
      if ($urandom_range(1)) begin
        for (int k = 0; k < eff; k++) text_buf.push_back(key_byte(k));
      end else begin
        repeat (eff) text_buf.push_back(noise_byte());
      end
    end else if (r < 25) begin
      for (int k = 0; k < eff; k++) text_buf.push_back(key_byte(k));
    end else if (r < 40) begin
      for (int k = 0; k < eff; k++) text_buf.push_back(key_byte(k));
      pos = $urandom_range(eff - 1);
      text_buf[pos] = text_buf[pos] ^ (8'h01 << $urandom_range(7));
    end else if (r < 65) begin
      repeat ($urandom_range(6)) text_buf.push_back(noise_byte());
      for (int k = 0; k < eff; k++) text_buf.push_back(key_byte(k));
      repeat ($urandom_range(6)) text_buf.push_back(noise_byte());
    end else if (r < 75) begin
      n = $urandom_range(eff + 3, 1);
      for (int k = 0; k < n; k++) text_buf.push_back(k < eff ? key_byte(k) : noise_byte());
    end else begin
      repeat ($urandom_range(20, 1)) text_buf.push_back(noise_byte());
    end
  endtask

  function automatic dir_row_t mk(input bit w, input logic [63:0] lo, hi, len_d, cont_d,
                                  input text_kind_e kind, input int n,
                                  input logic [7:0] fill, input int want);
    dir_row_t row;
    row.wr     = w;
    row.lo     = lo;
    row.hi     = hi;
    row.len_d  = len_d;
    row.cont_d = cont_d;
    row.kind   = kind;
    row.n      = n;
    row.fill   = fill;
    row.want   = want;
    return row;
  endfunction

  initial begin : stimulus
    dir_row_t    rows [$];
    logic [63:0] ones;
    logic [63:0] mix_lo;
    logic [63:0] mix_hi;
    logic [63:0] ab_key;
    ones   = '1;
    mix_lo = 64'h0123_4567_89AB_CDEF;
    mix_hi = 64'hFEDC_BA98_7654_3210;
    ab_key = 64'h4241_4241_4241_4241;
    // A want of -1 leaves the flag to the tracker.
    rows.push_back(mk(0, '0, '0, '0, '0, TXT_FILL, 1, 8'h00, 0));
    rows.push_back(mk(1, 64'hFF, '0, 1, 0, TXT_KEY, 1, 8'h00, 1));
    rows.push_back(mk(1, 64'hFF, '0, 1, 0, TXT_FILL, 1, 8'h00, 0));
    rows.push_back(mk(1, ones, ones, 16, 0, TXT_KEY, 16, 8'h00, 1));
    rows.push_back(mk(1, ones, ones, 16, 0, TXT_TAIL, 17, 8'h00, 0));
    rows.push_back(mk(1, ones, ones, 16, 1, TXT_TAIL, 17, 8'h00, 1));
    rows.push_back(mk(1, ones, ones, 16, 1, TXT_KEY, 15, 8'h00, 0));
    rows.push_back(mk(1, mix_lo, mix_hi, 16, 0, TXT_KEY, 16, 8'h00, 1));
    rows.push_back(mk(1, mix_lo, mix_hi, 16, 1, TXT_TAIL, 40, 8'h5A, 1));
    rows.push_back(mk(1, mix_lo, mix_hi, 64'hFFFF_FFFF_FFFF_FFE2, 0, TXT_KEY, 2, 8'h00, 1));
    rows.push_back(mk(1, mix_lo, mix_hi, 17, 0, TXT_KEY, 16, 8'h00, 0));
    rows.push_back(mk(1, mix_lo, mix_hi, 31, 1, TXT_TAIL, 20, 8'h00, 0));
    rows.push_back(mk(1, mix_lo, mix_hi, 0, 1, TXT_FILL, 3, 8'h00, 0));
    rows.push_back(mk(1, '0, '0, 1, ones, TXT_FILL, 5, 8'h00, 1));
    rows.push_back(mk(1, '0, '0, 1, 64'hFFFF_FFFF_FFFF_FFFE, TXT_FILL, 1, 8'h00, 1));
    rows.push_back(mk(1, '0, '0, 1, 0, TXT_FILL, 300, 8'h00, 0));
    rows.push_back(mk(1, 64'h42, '0, 1, 1, TXT_TAIL, 300, 8'h00, 1));
    rows.push_back(mk(1, ab_key, '0, 3, 1, TXT_KEY, 8, 8'h00, -1));
    rows.push_back(mk(1, ab_key, '0, 4, 0, TXT_KEY, 3, 8'h00, 0));
    rows.push_back(mk(1, ab_key, '0, 3, 0, TXT_KEY, 4, 8'h00, -1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      drain();
      if (rows[i].wr) program_key(rows[i].lo, rows[i].hi, rows[i].len_d, rows[i].cont_d);
      pinned_want = rows[i].want;
      build_text(rows[i].kind, rows[i].n, rows[i].fill);
      send_text();
    end
    drain();
    pinned_want = -1;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      program_random();
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 72;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 72;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      // The output stays blocked while bytes keep coming, so the input backs up.
      if (ph == 4) hold_left <= HOLD_CYCLES;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_text();
        send_text();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (match_q.size() != 0) report("text result never arrived", 1'bx, match_q[0]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
